// File: sv/vpl_pkg.sv
package vpl_pkg;

	localparam int ACTION_W   = 2;
	localparam int INDEX_W    = 8;
	localparam int VALUE_W    = 32;
	localparam int LEN_W      = 9;
	localparam int SUM_W      = VALUE_W + LEN_W + 1;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = LEN_W;

	localparam logic [ACTION_W-1:0] ACT_WR_DIST = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_WR_UNIV = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TABLE_MODE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH = 1'd1;

	localparam logic [LEN_W-1:0] LENGTH_RESET = 9'd256;

	// One unit in Q16.16.
	localparam logic signed [SUM_W-1:0] ONE_Q16 = 42'sd65536;

	typedef struct packed {
		logic take;
		logic start;
		logic walk;
		logic step;
		logic load_out;
	} vpl_cmd_t;

	typedef struct packed {
		logic walk_done;
	} vpl_stat_t;

endpackage

// File: sv/vpl_item_if.sv
interface vpl_item_if import vpl_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [ACTION_W-1:0]        action;
	logic [INDEX_W-1:0]         entry_index;
	logic signed [VALUE_W-1:0]  entry_value;
	logic                       entry_infinite;
	logic signed [VALUE_W-1:0]  query_distance;

	modport source (
		output valid, action, entry_index, entry_value, entry_infinite, query_distance,
		input ready
	);
	modport sink (
		input valid, action, entry_index, entry_value, entry_infinite, query_distance,
		output ready
	);
endinterface

// File: sv/vpl_result_if.sv
interface vpl_result_if import vpl_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [VALUE_W-1:0]  point_value;
	logic [INDEX_W-1:0]         found_index;
	logic                       status;

	modport source (
		output valid, point_value, found_index, status,
		input ready
	);
	modport sink (
		input valid, point_value, found_index, status,
		output ready
	);
endinterface

// File: sv/vpl_ram.sv
module vpl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: sv/vpl_ctrl.sv
module vpl_ctrl import vpl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  logic      item_is_query,
	input  logic      result_ready,
	input  vpl_stat_t stat,
	output vpl_cmd_t  cmd,
	output logic      item_ready,
	output logic      result_valid
);
	typedef enum logic [2:0] {S_IDLE, S_WALK, S_STEP, S_FETCH, S_LOAD} state_t;

	state_t state_q;
	logic   ready_q;
	logic   valid_q;
	logic   take;
	logic   slot_free;

	assign take      = item_valid & ready_q;
	assign slot_free = !valid_q | result_ready;

	always_comb begin
		cmd.take     = take;
		cmd.start    = take & item_is_query;
		cmd.walk     = (state_q == S_WALK);
		cmd.step     = (state_q == S_STEP);
		cmd.load_out = (state_q == S_LOAD) & slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						state_q <= S_WALK;
						ready_q <= 1'b0;
					end
				end
				S_WALK: begin
					if (stat.walk_done) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (slot_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase

			if (cmd.load_out) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign item_ready   = ready_q;
	assign result_valid = valid_q;
endmodule

// File: sv/vpl_datapath.sv
module vpl_datapath import vpl_pkg::*; #(
	parameter int MAX_ELEMENTS = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  vpl_cmd_t                  cmd,
	output vpl_stat_t                 stat,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic [ACTION_W-1:0]       action,
	input  logic [INDEX_W-1:0]        entry_index,
	input  logic signed [VALUE_W-1:0] entry_value,
	input  logic                      entry_infinite,
	input  logic signed [VALUE_W-1:0] query_distance,
	output logic signed [VALUE_W-1:0] point_value,
	output logic [INDEX_W-1:0]        found_index,
	output logic                      status
);
	localparam int ADDR_W = $clog2(MAX_ELEMENTS);

	logic                      mode_q;
	logic [LEN_W-1:0]          len_q;
	logic signed [VALUE_W-1:0] q_q;
	logic                      negq_q;
	logic [LEN_W-1:0]          n_m1_q;
	logic [LEN_W-1:0]          n_m1_next;
	logic [LEN_W-1:0]          rd_idx_q;
	logic                      beat_v_s1;
	logic [LEN_W-1:0]          beat_idx_s1;
	logic [VALUE_W:0]          best_q;
	logic                      best_inf_q;
	logic [LEN_W-1:0]          sel_q;
	logic                      oor_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [SUM_W-1:0]   prev_q;
	logic                      sinf_q;
	logic signed [VALUE_W-1:0] pv_q;
	logic [INDEX_W-1:0]        fi_q;
	logic                      st_q;

	logic                      wr_ok;
	logic                      dist_we;
	logic                      univ_we;
	logic [VALUE_W:0]          dist_rdata;
	logic [VALUE_W-1:0]        univ_rdata;

	logic signed [VALUE_W-1:0] dv;
	logic                      di;
	logic signed [VALUE_W:0]   dv_ext;
	logic signed [VALUE_W:0]   q_ext;
	logic [VALUE_W:0]          diff_a;
	logic [VALUE_W:0]          diff_b;
	logic [VALUE_W:0]          abs_diff;
	logic                      better;
	logic                      last_beat;
	logic                      first_beat;
	logic                      below;
	logic [LEN_W-1:0]          idx_inc;
	logic signed [SUM_W-1:0]   dv_sum;
	logic signed [SUM_W-1:0]   q_sum;
	logic signed [SUM_W-1:0]   cnt_next;
	logic signed [SUM_W-1:0]   sum_next;
	logic signed [SUM_W-1:0]   prev_next;
	logic                      neg_done;
	logic                      pos_done;
	logic signed [SUM_W-1:0]   over;
	logic signed [SUM_W-1:0]   under;
	logic                      do_back;

	assign wr_ok   = 32'(entry_index) < MAX_ELEMENTS;
	assign dist_we = cmd.take & (action == ACT_WR_DIST) & wr_ok;
	assign univ_we = cmd.take & (action == ACT_WR_UNIV) & wr_ok;

	vpl_ram #(.WIDTH(VALUE_W + 1), .DEPTH(MAX_ELEMENTS)) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (ADDR_W'(entry_index)),
		.wdata ({entry_infinite, entry_value}),
		.raddr (ADDR_W'(rd_idx_q)),
		.rdata (dist_rdata)
	);

	vpl_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ELEMENTS)) u_univ_ram (
		.clk   (clk),
		.we    (univ_we),
		.waddr (ADDR_W'(entry_index)),
		.wdata (entry_value),
		.raddr (ADDR_W'(sel_q)),
		.rdata (univ_rdata)
	);

	// The table length in use is clamped to the table depth and to at least two.
	always_comb begin
		if (len_q < LEN_W'(2)) begin
			n_m1_next = LEN_W'(1);
		end else if (32'(len_q) > MAX_ELEMENTS) begin
			n_m1_next = LEN_W'(MAX_ELEMENTS - 1);
		end else begin
			n_m1_next = len_q - 1'b1;
		end
	end

	assign dv     = dist_rdata[VALUE_W-1:0];
	assign di     = dist_rdata[VALUE_W];
	assign dv_ext = {dv[VALUE_W-1], dv};
	assign q_ext  = {q_q[VALUE_W-1], q_q};

	// Nearest search: both differences are formed and the positive one is kept.
	assign diff_a    = q_ext - dv_ext;
	assign diff_b    = dv_ext - q_ext;
	assign abs_diff  = diff_a[VALUE_W] ? diff_b : diff_a;
	assign better    = !di && (best_inf_q || (best_q > abs_diff));
	assign last_beat = (beat_idx_s1 == n_m1_q);

	// Cumulative walk.
	assign first_beat = (beat_idx_s1 == LEN_W'(1));
	assign below      = (beat_idx_s1 < n_m1_q);
	assign idx_inc    = beat_idx_s1 + 1'b1;
	assign dv_sum     = SUM_W'(dv);
	assign q_sum      = SUM_W'(q_q);
	assign cnt_next   = sum_q + (di ? ONE_Q16 : '0);
	assign neg_done   = !below || !(cnt_next[SUM_W-1] && (idx_inc < n_m1_q));

	always_comb begin
		if (first_beat) begin
			sum_next  = di ? '0 : dv_sum;
			prev_next = '0;
		end else begin
			sum_next  = di ? sum_q : sum_q + dv_sum;
			prev_next = sum_q;
		end
	end

	assign pos_done = !(!di && (sum_next < q_sum) && below);

	assign stat.walk_done = beat_v_s1 &
		(mode_q ? (negq_q ? neg_done : pos_done) : last_beat);

	// Step back one entry when the previous element lies closer to the query.
	assign over    = sum_q - q_sum;
	assign under   = q_sum - prev_q;
	assign do_back = mode_q & !negq_q & !sinf_q & (over > under);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			len_q     <= LENGTH_RESET;
			beat_v_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TABLE_MODE:   mode_q <= cfg_data[0];
					REG_TABLE_LENGTH: len_q  <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			beat_v_s1 <= cmd.walk & !stat.walk_done;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			q_q      <= query_distance;
			negq_q   <= query_distance[VALUE_W-1];
			n_m1_q   <= n_m1_next;
			rd_idx_q <= mode_q ? LEN_W'(1) : '0;
			sel_q    <= mode_q ? LEN_W'(1) : '0;
			sum_q    <= SUM_W'(query_distance);
			oor_q    <= 1'b0;
		end

		if (cmd.walk) begin
			rd_idx_q    <= rd_idx_q + 1'b1;
			beat_idx_s1 <= rd_idx_q;
		end

		if (cmd.walk && beat_v_s1) begin
			if (!mode_q) begin
				if (beat_idx_s1 == '0) begin
					best_inf_q <= di;
					best_q     <= abs_diff;
					sel_q      <= '0;
				end else if (better) begin
					best_inf_q <= 1'b0;
					best_q     <= abs_diff;
					sel_q      <= beat_idx_s1;
				end
				if (last_beat) begin
					oor_q <= q_q[VALUE_W-1] | (!di & (q_q > dv));
				end
			end else if (negq_q) begin
				// A negative query counts infinite entries, one unit each.
				if (below) begin
					sum_q <= cnt_next;
					sel_q <= idx_inc;
				end else begin
					sel_q <= beat_idx_s1;
				end
			end else begin
				sum_q  <= sum_next;
				prev_q <= prev_next;
				sinf_q <= di;
				sel_q  <= beat_idx_s1;
			end
		end

		if (cmd.step && do_back) begin
			sel_q <= sel_q - 1'b1;
		end

		if (cmd.load_out) begin
			pv_q <= oor_q ? '0 : univ_rdata;
			fi_q <= oor_q ? '0 : sel_q[INDEX_W-1:0];
			st_q <= oor_q;
		end
	end

	assign point_value = pv_q;
	assign found_index = fi_q;
	assign status      = st_q;
endmodule

// File: sv/vague_point_lookup_unit.sv
// Channel   Role    Beat contents
// item      sink    action, entry_index, entry_value, entry_infinite, query_distance
// result    source  point_value, found_index, status (one beat per query)
// cfg       write   cfg_we, cfg_index (0 table_mode, 1 table_length), cfg_data
//
// A write beat leaves the input ready. A query goes from its accepting edge to the result
// beat in these steps: starting the RAM, reading the clamped length of the distance table
// one entry per cycle, a step-back state, one universe RAM read and the load.
// In the cumulative mode the walk starts at entry one and may end early.
// Reset covers the controller, mode and length; the tables hold nothing until written.
// A finished result waits in the output register while a new item may be accepted; a query
// whose result finds the output still full waits until that beat is taken.
module vague_point_lookup_unit import vpl_pkg::*; #(
	parameter int MAX_ELEMENTS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	vpl_item_if.sink              item,
	vpl_result_if.source          result
);
	vpl_cmd_t  cmd;
	vpl_stat_t stat;

	vpl_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item.valid),
		.item_is_query (item.action == ACT_QUERY),
		.result_ready  (result.ready),
		.stat          (stat),
		.cmd           (cmd),
		.item_ready    (item.ready),
		.result_valid  (result.valid)
	);

	vpl_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.action         (item.action),
		.entry_index    (item.entry_index),
		.entry_value    (item.entry_value),
		.entry_infinite (item.entry_infinite),
		.query_distance (item.query_distance),
		.point_value    (result.point_value),
		.found_index    (result.found_index),
		.status         (result.status)
	);
endmodule

// File: sv/vpl_checker.sv
module vpl_port_checks import vpl_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      item_valid,
	input logic                      item_ready,
	input logic [ACTION_W-1:0]       item_action,
	input logic                      result_valid,
	input logic                      result_ready,
	input logic signed [VALUE_W-1:0] result_point,
	input logic [INDEX_W-1:0]        result_index,
	input logic                      result_status
);
	// A stalled result beat stays put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_point)
			&& $stable(result_index) && $stable(result_status))
		else $error("result beat changed while stalled");

	// An out-of-range answer carries a zero point and index.
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_status |-> result_point == '0 && result_index == '0)
		else $error("out-of-range result with nonzero payload");

	// A query occupies the block, so no item follows it right away.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_action == ACT_QUERY |=> !item_ready)
		else $error("item accepted right after a query");

	// Table writes never block the input.
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_action != ACT_QUERY |=> item_ready)
		else $error("input blocked after a write");

	// A fresh result appears only as the block returns to accepting items.
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> item_ready)
		else $error("result raised while a query is still at work");
endmodule

bind vague_point_lookup_unit vpl_port_checks u_vpl_port_checks (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.item_action   (item.action),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.result_point  (result.point_value),
	.result_index  (result.found_index),
	.result_status (result.status)
);

// File: tb/vpl_tb_pkg.sv
package vpl_tb_pkg;

	localparam int TABLE_DEPTH = 256;

	// Search modes held in table_mode.
	localparam logic MODE_INTEGRAL = 1'b0;
	localparam logic MODE_STEPS    = 1'b1;

	localparam logic [vpl_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

	localparam logic STATUS_FOUND = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	localparam longint Q16_ONE = 65536;

endpackage

// File: tb/vpl_checker.sv
module vpl_checker import vpl_pkg::*; import vpl_tb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	vpl_item_if                   item,
	vpl_result_if                 result,
	output int                    mismatches,
	output int                    awaited
);

	localparam longint SUM_TOP    = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint SUM_BOTTOM = -SUM_TOP - 1;

	typedef struct packed {
		logic signed [VALUE_W-1:0] point;
		logic [INDEX_W-1:0]        idx;
		logic                      status;
	} lookup_t;

	lookup_t expected_points [$];

	longint                    distances [TABLE_DEPTH];
	bit                        infinite  [TABLE_DEPTH];
	logic signed [VALUE_W-1:0] universe  [TABLE_DEPTH];
	logic                      table_mode;
	logic [LEN_W-1:0]          table_length;

	function automatic longint sum_sat(longint a, longint b);
		if (b > 0 && a > SUM_TOP - b)
			return SUM_TOP;
		if (b < 0 && a < SUM_BOTTOM - b)
			return SUM_BOTTOM;
		return a + b;
	endfunction

	function automatic longint diff_sat(longint a, longint b);
		if (b < 0 && a > SUM_TOP + b)
			return SUM_TOP;
		if (b > 0 && a < SUM_BOTTOM + b)
			return SUM_BOTTOM;
		return a - b;
	endfunction

	function automatic longint unsigned spread(longint a, longint b);
		return (a >= b) ? longint'(a - b) : longint'(b - a);
	endfunction

	function automatic lookup_t lookup_point(logic signed [VALUE_W-1:0] query);
		int               n;
		int               i;
		int               k;
		longint           q;
		longint           c;
		longint           s;
		longint           over;
		longint           under;
		bit               s_inf;
		bit               best_inf;
		longint unsigned  best;
		longint unsigned  d;
		lookup_t          r;
		n = table_length;
		if (n < 2)
			n = 2;
		if (n > TABLE_DEPTH)
			n = TABLE_DEPTH;
		q = query;
		i = 0;
		r.status = STATUS_FOUND;
		if (table_mode == MODE_INTEGRAL) begin
			if (q < 0 || (!infinite[n-1] && q > distances[n-1])) begin
				r.status = STATUS_RANGE;
			end else begin
				// Infinite entries are never nearer than a finite one.
				best_inf = infinite[0];
				best = best_inf ? 0 : spread(distances[0], q);
				for (k = 1; k < n; k++) begin
					if (!infinite[k]) begin
						d = spread(distances[k], q);
						if (best_inf || best > d) begin
							best = d;
							best_inf = 0;
							i = k;
						end
					end
				end
			end
		end else begin
			i = 1;
			if (q < 0) begin
				// A negative query counts infinite entries, one unit each.
				c = q;
				while (c < 0 && i < n - 1) begin
					if (infinite[i])
						c += Q16_ONE;
					i++;
				end
			end else begin
				s_inf = infinite[i];
				s = s_inf ? 0 : distances[i];
				while (!s_inf && s < q && i < n - 1) begin
					i++;
					if (infinite[i])
						s_inf = 1;
					else
						s = sum_sat(s, distances[i]);
				end
				if (!s_inf) begin
					over = diff_sat(s, q);
					under = diff_sat(q, diff_sat(s, distances[i]));
					if (over > under)
						i--;
				end
			end
		end
		if (r.status == STATUS_RANGE) begin
			r.point = '0;
			r.idx = '0;
		end else begin
			r.point = universe[i];
			r.idx = INDEX_W'(i);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_t want;
		if (!arst_n) begin
			table_mode = MODE_INTEGRAL;
			table_length = LENGTH_RESET;
			expected_points.delete();
			mismatches = 0;
			awaited = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_TABLE_MODE)
					table_mode = cfg_data[0];
				else if (cfg_index == REG_TABLE_LENGTH)
					table_length = cfg_data[LEN_W-1:0];
			end
			if (result.valid && result.ready) begin
				if (expected_points.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with none expected: got point %h index %0d status %0d",
						$time, result.point_value, result.found_index, result.status);
				end else begin
					want = expected_points.pop_front();
					if (result.point_value !== want.point || result.found_index !== want.idx ||
							result.status !== want.status) begin
						mismatches++;
						$display("%0t: expected point %h index %0d status %0d, got point %h index %0d status %0d",
							$time, want.point, want.idx, want.status,
							result.point_value, result.found_index, result.status);
					end
				end
			end
			if (item.valid && item.ready) begin
				case (item.action)
					ACT_WR_DIST: begin
						distances[item.entry_index] = item.entry_value;
						infinite[item.entry_index] = item.entry_infinite;
					end
					ACT_WR_UNIV: begin
						universe[item.entry_index] = item.entry_value;
					end
					ACT_QUERY: begin
						expected_points.push_back(lookup_point(item.query_distance));
					end
					default: begin
					end
				endcase
			end
			awaited = expected_points.size();
		end
	end

endmodule

// File: tb/tb_top.sv
module tb_top;
	import vpl_pkg::*;
	import vpl_tb_pkg::*;

	// Wait bound for the longest query: the clamped length walk, the step-back and the universe read.
	localparam int QUERY_CYCLES = 270;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    awaited;
	int                    send_idle_pct = 22;
	int                    take_idle_pct = 67;
	int                    items_sent = 0;
	longint                reach;

	vpl_item_if   item ();
	vpl_result_if result ();

	vague_point_lookup_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.result    (result)
	);

	vpl_checker lookup_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item       (item),
		.result     (result),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("** vague_point_lookup_unit: FAILED **");
		$finish;
	end

	initial begin
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			result.ready <= ($urandom_range(99) >= take_idle_pct);
		end
	end

	task automatic send_beat(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] idx,
			logic signed [VALUE_W-1:0] value, logic inf, logic signed [VALUE_W-1:0] target);
		while ($urandom_range(99) < send_idle_pct) begin
			item.valid <= 1'b0;
			@(negedge clk);
		end
		item.valid <= 1'b1;
		item.action <= act;
		item.entry_index <= idx;
		item.entry_value <= value;
		item.entry_infinite <= inf;
		item.query_distance <= target;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_distance(int idx, logic signed [VALUE_W-1:0] value, logic inf);
		send_beat(ACT_WR_DIST, INDEX_W'(idx), value, inf, $urandom);
	endtask

	// The infinity bit is random here: the block must ignore it on universe beats.
	task automatic write_point(int idx, logic signed [VALUE_W-1:0] value);
		send_beat(ACT_WR_UNIV, INDEX_W'(idx), value, 1'($urandom_range(1)), $urandom);
	endtask

	task automatic ask(logic signed [VALUE_W-1:0] target);
		send_beat(ACT_QUERY, INDEX_W'($urandom), $urandom, 1'($urandom_range(1)), target);
	endtask

	task automatic settle();
		item.valid <= 1'b0;
		while (awaited != 0)
			@(negedge clk);
		repeat (QUERY_CYCLES) @(negedge clk);
	endtask

	task automatic set_registers(logic mode, logic [LEN_W-1:0] len);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_TABLE_MODE;
		cfg_data <= CFG_DATA_W'(mode);
		@(negedge clk);
		cfg_index <= REG_TABLE_LENGTH;
		cfg_data <= len;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Fills entries 0..n-1 so that no query reads an unwritten entry. Integral mode gets a
	// non-decreasing table with repeats; step mode gets small non-negative differences.
	task automatic load_tables(logic mode, int n);
		longint level;
		longint value;
		logic   inf;
		level = (mode == MODE_INTEGRAL) ? $urandom_range(0, 2 * 65536) : 0;
		for (int k = 0; k < n; k++) begin
			inf = ($urandom_range(11) == 0);
			if (mode == MODE_INTEGRAL) begin
				if (k > 0 && $urandom_range(3) != 0)
					level += $urandom_range(1, 3 * 65536);
				value = level;
			end else begin
				value = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 3 * 65536);
				if (!inf)
					level += value;
			end
			write_distance(k, VALUE_W'(value), inf);
			write_point(k, $urandom);
		end
		reach = level;
	endtask

	task automatic mixed_traffic(int count);
		int r;
		int pick;
		for (int j = 0; j < count; j++) begin
			r = $urandom_range(99);
			if (r < 60) begin
				pick = $urandom_range(99);
				if (pick < 60)
					ask(VALUE_W'($urandom_range(0, 32'(reach))));
				else if (pick < 70)
					ask(VALUE_W'(reach + $urandom_range(1, 65536)));
				else if (pick < 82)
					ask(0 - int'($urandom_range(1, 6 * 65536)));
				else if (pick < 95)
					ask($urandom);
				else
					ask(0);
			end else if (r < 72) begin
				write_distance($urandom_range(255),
					$urandom_range(1) ? $urandom : $urandom_range(0, 3 * 65536),
					1'($urandom_range(1)));
			end else if (r < 86) begin
				write_point($urandom_range(255), $urandom);
			end else begin
				send_beat(ACT_UNUSED, INDEX_W'($urandom), $urandom, 1'($urandom_range(1)),
					$urandom);
			end
		end
	endtask

	initial begin
		int               n;
		logic             mode;
		logic [LEN_W-1:0] len;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item.valid = 1'b0;
		item.action = ACT_WR_DIST;
		item.entry_index = '0;
		item.entry_value = '0;
		item.entry_infinite = 1'b0;
		item.query_distance = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Integral mode on four entries: 0, 1.0, 2.5, 4.0.
		set_registers(MODE_INTEGRAL, 9'd4);
		write_distance(0, 0, 1'b0);
		write_distance(1, 32'sd65536, 1'b0);
		write_distance(2, 32'sd163840, 1'b0);
		write_distance(3, 32'sd262144, 1'b0);
		write_point(0, 32'sh7FFF_FFFF);
		write_point(1, 32'sh8000_0000);
		write_point(2, -1);
		write_point(3, 32'sh1234_5678);
		ask(-1);
		ask(32'sh8000_0000);
		ask(32'sd262144);
		ask(32'sd262145);
		// Halfway between 1.0 and 2.5: the lower index wins the tie.
		ask(32'sd114688);
		// An infinite last entry keeps even the largest query in range.
		write_distance(3, 32'sh7FFF_FFFF, 1'b1);
		ask(32'sh7FFF_FFFF);
		write_distance(0, 0, 1'b1);
		write_distance(1, 0, 1'b1);
		write_distance(2, 0, 1'b1);
		ask(32'sd65536);
		send_beat(ACT_UNUSED, 8'hFF, -1, 1'b1, -1);

		// Step mode: unit differences, then one infinite difference.
		set_registers(MODE_STEPS, 9'd4);
		write_distance(1, 32'sd65536, 1'b0);
		write_distance(2, 32'sd65536, 1'b0);
		write_distance(3, 32'sd65536, 1'b0);
		ask(0);
		ask(32'sd157286);
		ask(32'sh7FFF_FFFF);
		write_distance(2, 0, 1'b1);
		ask(32'sh7FFF_FFFF);
		ask(-32'sd65536);
		ask(32'sh8000_0000);

		// Register values below two clamp the length to two.
		set_registers(MODE_INTEGRAL, 9'd0);
		load_tables(MODE_INTEGRAL, 2);
		mixed_traffic(20);
		set_registers(MODE_STEPS, 9'd1);
		load_tables(MODE_STEPS, 2);
		mixed_traffic(20);

		while (items_sent < 450) begin
			if (items_sent >= 300) begin
				send_idle_pct = 0;
				take_idle_pct = 0;
			end else if (items_sent >= 150) begin
				send_idle_pct = 67;
				take_idle_pct = 22;
			end
			mode = 1'($urandom_range(1));
			case ($urandom_range(19))
				0, 1, 2:  len = LEN_W'($urandom_range(17, 40));
				3:        len = LEN_W'($urandom_range(0, 1));
				default:  len = LEN_W'($urandom_range(2, 16));
			endcase
			n = (len < 2) ? 2 : int'(len);
			set_registers(mode, len);
			load_tables(mode, n);
			mixed_traffic(20);
		end

		settle();
		if (mismatches == 0)
			$display("** vague_point_lookup_unit: PASSED **");
		else
			$display("** vague_point_lookup_unit: FAILED **");
		$finish;
	end

endmodule
